### sv/rps_pkg.sv
// shared types, constants and helpers for the record page store
package rps_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int LANES      = 8;
    localparam int LANE_W     = $clog2(LANES);
    localparam int ROWS       = PAGE_BYTES / LANES;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int ADDR_W     = $clog2(PAGE_BYTES) + 1;
    localparam int DATA_W     = 64;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_SEARCH = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        CFG_KEY_BYTES   = 1'b0,
        CFG_ENTRY_BYTES = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_GOT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [3:0]        nbytes;
    } wr_req_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

    function automatic logic [DATA_W-1:0] byte_mask(input logic [3:0] n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < LANES; i++) begin
            if (4'(i) < n) begin
                m[8*i +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

### sv/record_page_store_with_key_search_top.sv
// record page store top level: control sequencer, config registers, output register
// append: one page memory write when the record fits; clear: fill level reset to zero, no write
// read at offset: one banked memory read of 8 byte lanes
// search: each entry walked is read then compared; a matching entry is sent in chunks of up to 8 bytes
// one request at a time; the next request is taken while the last result waits
// reset: synchronous active low, fill level and config registers cleared to defaults
module record_page_store_with_key_search_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // payload[63:0], nbytes[67:64], offset[79:68]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // data[63:0], valid_bytes[67:64], fill[80:68], zero
    output logic [0:0]  m_tuser,   // ok[0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int AW = rps_pkg::ADDR_W;
    localparam int DW = rps_pkg::DATA_W;

    rps_pkg::state_t  state_reg, state_next;
    rps_pkg::op_t     op_reg, op_next;
    logic [AW-1:0]    fill_reg, fill_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [DW-1:0]    key_reg, key_next;
    logic [3:0]       n_reg, n_next;
    logic             found_reg, found_next;
    logic [6:0]       sent_reg, sent_next;
    logic [3:0]       kb_cfg_reg;
    logic [6:0]       eb_cfg_reg;

    logic             res_ok_reg, res_ok_next;
    logic [DW-1:0]    res_data_reg, res_data_next;
    logic [3:0]       res_vb_reg, res_vb_next;
    logic             res_last_reg, res_last_next;

    logic             m_tvalid_reg;
    logic             out_ok_reg;
    logic [DW-1:0]    out_data_reg;
    logic [3:0]       out_vb_reg;
    logic             out_last_reg;
    logic [AW-1:0]    out_fill_reg;
    logic             out_load;

    rps_pkg::wr_req_t wr_req;
    rps_pkg::rd_req_t rd_req;
    logic [DW-1:0]    rd_data;

    logic             s_acc;
    logic [3:0]       in_n;
    logic [11:0]      in_off;
    logic [3:0]       kb;
    logic [6:0]       eb;
    logic [DW-1:0]    vis_mask;
    logic [DW-1:0]    got;
    logic [DW-1:0]    kmask;
    logic [6:0]       remain;
    logic [3:0]       chunk;
    logic [AW:0]      next_pos;

    rps_page_mem u_mem (
        .aclk    (aclk),
        .wr_req  (wr_req),
        .rd_req  (rd_req),
        .rd_data (rd_data)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == rps_pkg::ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign in_n      = (s_tdata[67:64] > 4'd8) ? 4'd8 : s_tdata[67:64];
    assign in_off    = s_tdata[79:68];
    assign kb        = (kb_cfg_reg == 4'd0) ? 4'd1 :
                       (kb_cfg_reg > 4'd8) ? 4'd8 : kb_cfg_reg;
    assign eb        = (eb_cfg_reg == 7'd0) ? 7'd1 :
                       (eb_cfg_reg > 7'd64) ? 7'd64 : eb_cfg_reg;
    assign out_load  = !m_tvalid_reg || m_tready;
    assign remain    = eb - sent_reg;
    assign chunk     = (remain > 7'd8) ? 4'd8 : remain[3:0];
    assign kmask     = rps_pkg::byte_mask(kb);
    assign next_pos  = {1'b0, addr_reg} + (AW+1)'(eb);

    always_comb begin
        for (int i = 0; i < rps_pkg::LANES; i++) begin
            vis_mask[8*i +: 8] = (({1'b0, addr_reg} + (AW+1)'(i)) < {1'b0, fill_reg})
                                 ? 8'hff : 8'h00;
        end
        got = rd_data & vis_mask;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kb_cfg_reg <= 4'd4;
            eb_cfg_reg <= 7'd8;
        end else if (cfg_valid && cfg_ready) begin
            unique case (rps_pkg::cfg_idx_t'(cfg_index))
                rps_pkg::CFG_KEY_BYTES:   kb_cfg_reg <= cfg_data[3:0];
                rps_pkg::CFG_ENTRY_BYTES: eb_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rps_pkg::ST_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        key_reg      <= key_next;
        n_reg        <= n_next;
        found_reg    <= found_next;
        sent_reg     <= sent_next;
        res_ok_reg   <= res_ok_next;
        res_data_reg <= res_data_next;
        res_vb_reg   <= res_vb_next;
        res_last_reg <= res_last_next;
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        fill_next     = fill_reg;
        addr_next     = addr_reg;
        key_next      = key_reg;
        n_next        = n_reg;
        found_next    = found_reg;
        sent_next     = sent_reg;
        res_ok_next   = res_ok_reg;
        res_data_next = res_data_reg;
        res_vb_next   = res_vb_reg;
        res_last_next = res_last_reg;
        wr_req        = '0;
        rd_req        = '0;
        unique case (state_reg)
            rps_pkg::ST_IDLE: begin
                if (s_acc) begin
                    op_next       = rps_pkg::op_t'(s_tuser);
                    key_next      = s_tdata[63:0];
                    n_next        = in_n;
                    found_next    = 1'b0;
                    sent_next     = '0;
                    res_ok_next   = 1'b0;
                    res_data_next = '0;
                    res_vb_next   = '0;
                    res_last_next = 1'b1;
                    state_next    = rps_pkg::ST_EMIT;
                    unique case (rps_pkg::op_t'(s_tuser))
                        rps_pkg::OP_APPEND: begin
                            if (({1'b0, fill_reg} + (AW+1)'(in_n))
                                    <= (AW+1)'(rps_pkg::PAGE_BYTES)) begin
                                wr_req.en     = 1'b1;
                                wr_req.addr   = fill_reg;
                                wr_req.data   = s_tdata[63:0];
                                wr_req.nbytes = in_n;
                                fill_next     = fill_reg + AW'(in_n);
                                res_ok_next   = 1'b1;
                            end
                        end
                        rps_pkg::OP_SEARCH: begin
                            addr_next = '0;
                            if (fill_reg != '0) begin
                                state_next = rps_pkg::ST_FETCH;
                            end
                        end
                        rps_pkg::OP_READ: begin
                            addr_next = AW'(in_off);
                            if ((AW'(in_off) + AW'(in_n)) <= fill_reg) begin
                                state_next = rps_pkg::ST_FETCH;
                            end
                        end
                        rps_pkg::OP_CLEAR: begin
                            fill_next   = '0;
                            res_ok_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            rps_pkg::ST_FETCH: begin
                rd_req.en   = 1'b1;
                rd_req.addr = addr_reg;
                state_next  = rps_pkg::ST_GOT;
            end
            rps_pkg::ST_GOT: begin
                state_next = rps_pkg::ST_EMIT;
                if (op_reg == rps_pkg::OP_READ) begin
                    res_ok_next   = 1'b1;
                    res_data_next = got & rps_pkg::byte_mask(n_reg);
                    res_vb_next   = n_reg;
                    res_last_next = 1'b1;
                end else if (found_reg) begin
                    res_ok_next   = 1'b1;
                    res_data_next = got & rps_pkg::byte_mask(chunk);
                    res_vb_next   = chunk;
                    res_last_next = (sent_reg + 7'(chunk)) >= eb;
                    sent_next     = sent_reg + 7'(chunk);
                    addr_next     = addr_reg + AW'(chunk);
                end else if ((got & kmask) == (key_reg & kmask)) begin
                    found_next = 1'b1;
                    sent_next  = '0;
                    state_next = rps_pkg::ST_FETCH;
                end else if (next_pos < {1'b0, fill_reg}) begin
                    addr_next  = next_pos[AW-1:0];
                    state_next = rps_pkg::ST_FETCH;
                end else begin
                    res_ok_next   = 1'b0;
                    res_data_next = '0;
                    res_vb_next   = '0;
                    res_last_next = 1'b1;
                end
            end
            rps_pkg::ST_EMIT: begin
                if (out_load) begin
                    state_next = res_last_reg ? rps_pkg::ST_IDLE : rps_pkg::ST_FETCH;
                end
            end
            default: state_next = rps_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == rps_pkg::ST_EMIT && out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (state_reg == rps_pkg::ST_EMIT && out_load) begin
            out_ok_reg   <= res_ok_reg;
            out_data_reg <= res_data_reg;
            out_vb_reg   <= res_vb_reg;
            out_last_reg <= res_last_reg;
            out_fill_reg <= fill_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_fill_reg, out_vb_reg, out_data_reg};
    assign m_tuser  = out_ok_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= AW'(rps_pkg::PAGE_BYTES))
        else $error("fill level beyond page size");

    a_clear_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser == rps_pkg::OP_CLEAR) |=> (fill_reg == '0))
        else $error("clear did not reset fill level");

    a_chunk_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tuser[0] && m_tdata[67:64] == 4'd8))
        else $error("non-final result is not a full found chunk");

    a_busy_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rps_pkg::ST_GOT) |-> $stable(fill_reg))
        else $error("fill changed during a memory walk");
`endif

endmodule

### sv/rps_page_mem.sv
// byte-lane banked page memory with unaligned 8-byte read and write
module rps_page_mem (
    input  logic                             aclk,
    input  rps_pkg::wr_req_t                 wr_req,
    input  rps_pkg::rd_req_t                 rd_req,
    output logic [rps_pkg::DATA_W-1:0]       rd_data
);

    localparam int ROW_SUM_W = rps_pkg::ADDR_W - rps_pkg::LANE_W;

    logic [7:0]                  lane_q [rps_pkg::LANES];
    logic [rps_pkg::LANE_W-1:0]  rd_sh_reg;

    for (genvar b = 0; b < rps_pkg::LANES; b++) begin : g_lane
        logic [7:0]                  mem [rps_pkg::ROWS];
        logic [rps_pkg::LANE_W-1:0]  wj;
        logic [ROW_SUM_W-1:0]        wrow;
        logic [ROW_SUM_W-1:0]        rrow;
        logic                        wsel;

        always_comb begin
            wj   = rps_pkg::LANE_W'(b) - wr_req.addr[rps_pkg::LANE_W-1:0];
            wsel = wr_req.en && ({1'b0, wj} < wr_req.nbytes);
            wrow = wr_req.addr[rps_pkg::ADDR_W-1:rps_pkg::LANE_W]
                 + ROW_SUM_W'(rps_pkg::LANE_W'(b) < wr_req.addr[rps_pkg::LANE_W-1:0]);
            rrow = rd_req.addr[rps_pkg::ADDR_W-1:rps_pkg::LANE_W]
                 + ROW_SUM_W'(rps_pkg::LANE_W'(b) < rd_req.addr[rps_pkg::LANE_W-1:0]);
        end

        always_ff @(posedge aclk) begin
            if (wsel) begin
                mem[wrow[rps_pkg::ROW_W-1:0]] <= wr_req.data[8*wj +: 8];
            end
            if (rd_req.en) begin
                lane_q[b] <= mem[rrow[rps_pkg::ROW_W-1:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_req.en) begin
            rd_sh_reg <= rd_req.addr[rps_pkg::LANE_W-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < rps_pkg::LANES; i++) begin
            rd_data[8*i +: 8] = lane_q[rd_sh_reg + rps_pkg::LANE_W'(i)];
        end
    end

endmodule

### tb/sv/tb.sv
// testbench for the record page store: queued stimulus, clocked driver and monitor, scoreboard
`timescale 1ns / 1ps
module tb;

    typedef struct packed {
        rps_pkg::op_t op;
        logic [63:0]  payload;
        logic [3:0]   nbytes;
        logic [11:0]  offset;
    } request_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] data;
        logic [3:0]  valid_bytes;
        logic        last;
        logic [12:0] fill;
    } result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [6:0]  cfg_data;

    record_page_store_with_key_search_top dut (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    request_t    pending_reqs[$];
    result_t     expected_results[$];
    logic [7:0]  page_model[rps_pkg::PAGE_BYTES];
    int unsigned fill_model;
    int unsigned key_len;
    int unsigned entry_len;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;
    int          errors;
    int          quiet_cycles;

    function automatic logic [7:0] page_byte(int unsigned pos);
        return pos < rps_pkg::PAGE_BYTES ? page_model[pos] : 8'h00;
    endfunction

    function automatic logic [63:0] collect_bytes(int unsigned pos, int unsigned n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n && i < 8; i++) begin
            v[8*i +: 8] = page_byte(pos + i);
        end
        return v;
    endfunction

    function automatic result_t make_result(logic ok, logic [63:0] d, int unsigned vb,
                                            logic lst);
        result_t r;
        r.ok = ok;
        r.data = d;
        r.valid_bytes = 4'(vb);
        r.last = lst;
        r.fill = 13'(fill_model);
        return r;
    endfunction

    task automatic predict_store(request_t rq);
        int unsigned n;
        int unsigned kb;
        int unsigned eb;
        int unsigned sent;
        int unsigned c;
        logic [63:0] kmask;
        logic        found;
        n = rq.nbytes > 8 ? 8 : rq.nbytes;
        case (rq.op)
            rps_pkg::OP_APPEND: begin
                if (fill_model + n <= rps_pkg::PAGE_BYTES) begin
                    for (int i = 0; i < n; i++) begin
                        page_model[fill_model + i] = rq.payload[8*i +: 8];
                    end
                    fill_model += n;
                    expected_results.push_back(make_result(1, 0, 0, 1));
                end else begin
                    expected_results.push_back(make_result(0, 0, 0, 1));
                end
            end
            rps_pkg::OP_SEARCH: begin
                kb = key_len < 1 ? 1 : (key_len > 8 ? 8 : key_len);
                eb = entry_len < 1 ? 1 : (entry_len > 64 ? 64 : entry_len);
                kmask = kb >= 8 ? '1 : ((64'd1 << (8 * kb)) - 1);
                found = 1'b0;
                for (int unsigned pos = 0; pos < fill_model && !found; pos += eb) begin
                    if ((collect_bytes(pos, kb) & kmask) == (rq.payload & kmask)) begin
                        found = 1'b1;
                        sent = 0;
                        while (sent < eb) begin
                            c = (eb - sent) > 8 ? 8 : eb - sent;
                            expected_results.push_back(make_result(1,
                                collect_bytes(pos + sent, c), c, sent + c >= eb));
                            sent += c;
                        end
                    end
                end
                if (!found) begin
                    expected_results.push_back(make_result(0, 0, 0, 1));
                end
            end
            rps_pkg::OP_READ: begin
                if (rq.offset + n <= fill_model) begin
                    expected_results.push_back(make_result(1, collect_bytes(rq.offset, n),
                                                           n, 1));
                end else begin
                    expected_results.push_back(make_result(0, 0, 0, 1));
                end
            end
            default: begin
                for (int i = 0; i < rps_pkg::PAGE_BYTES; i++) begin
                    page_model[i] = 8'h00;
                end
                fill_model = 0;
                expected_results.push_back(make_result(1, 0, 0, 1));
            end
        endcase
    endtask

    function automatic request_t make_req(rps_pkg::op_t op, logic [63:0] p, int unsigned n,
                                          int unsigned off);
        request_t rq;
        rq.op = op;
        rq.payload = p;
        rq.nbytes = 4'(n);
        rq.offset = 12'(off);
        return rq;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                predict_store(pending_reqs.pop_front());
            end
            if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= {pending_reqs[0].offset, pending_reqs[0].nbytes,
                            pending_reqs[0].payload};
                s_tuser <= pending_reqs[0].op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected");
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser[0] !== want.ok) begin
                        $error("ok: expected %0h actual %0h", want.ok, m_tuser[0]);
                        errors++;
                    end
                    if (m_tdata[63:0] !== want.data) begin
                        $error("data: expected %0h actual %0h", want.data, m_tdata[63:0]);
                        errors++;
                    end
                    if (m_tdata[67:64] !== want.valid_bytes) begin
                        $error("valid_bytes: expected %0d actual %0d", want.valid_bytes,
                               m_tdata[67:64]);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %0d actual %0d", want.last, m_tlast);
                        errors++;
                    end
                    if (m_tdata[80:68] !== want.fill) begin
                        $error("fill: expected %0d actual %0d", want.fill, m_tdata[80:68]);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= $urandom_range(99, 0) >= recv_idle_pct;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 200000) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0) begin
            @(posedge aclk);
        end
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(rps_pkg::cfg_idx_t idx, int unsigned value);
        cfg_index <= idx;
        cfg_data <= 7'(value);
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            rps_pkg::CFG_KEY_BYTES: key_len = value & 4'hf;
            default: entry_len = value & 7'h7f;
        endcase
    endtask

    // well-formed records and searches for their keys, plus noise
    task automatic queue_random(int count);
        logic [63:0] keys[$];
        int          r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99, 0);
            if (r < 35) begin
                keys.push_back(rand64());
                pending_reqs.push_back(make_req(rps_pkg::OP_APPEND, keys[$],
                                                $urandom_range(3) == 0 ? $urandom_range(15, 0)
                                                                       : 8, 0));
            end else if (r < 60) begin
                pending_reqs.push_back(make_req(rps_pkg::OP_SEARCH,
                    (keys.size() > 0 && $urandom_range(3) != 0)
                        ? keys[$urandom_range(keys.size() - 1)] : rand64(), 0, 0));
            end else if (r < 85) begin
                pending_reqs.push_back(make_req(rps_pkg::OP_READ, rand64(),
                    $urandom_range(15, 0),
                    $urandom_range(7) == 0 ? $urandom_range(4095, 0)
                                           : $urandom_range(fill_model + 64, 0)));
            end else if (r < 97) begin
                pending_reqs.push_back(make_req(rps_pkg::OP_APPEND, rand64(),
                                                $urandom_range(15, 0),
                                                $urandom_range(4095, 0)));
            end else begin
                pending_reqs.push_back(make_req(rps_pkg::OP_CLEAR, rand64(),
                                                $urandom_range(15, 0),
                                                $urandom_range(4095, 0)));
                keys.delete();
            end
        end
    endtask

    initial begin
        errors = 0;
        hold_cycles = 0;
        send_idle_pct = 12;
        recv_idle_pct = 87;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet_cycles = 0;
        fill_model = 0;
        key_len = 4;
        entry_len = 8;
        for (int i = 0; i < rps_pkg::PAGE_BYTES; i++) begin
            page_model[i] = 8'h00;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, every op, size corner cases, on reset config
        pending_reqs.push_back(make_req(rps_pkg::OP_SEARCH, 64'h0, 8, 0));
        pending_reqs.push_back(make_req(rps_pkg::OP_READ, 64'h0, 0, 0));
        pending_reqs.push_back(make_req(rps_pkg::OP_READ, 64'h0, 1, 0));
        pending_reqs.push_back(make_req(rps_pkg::OP_APPEND, '1, 8, 12'hfff));
        pending_reqs.push_back(make_req(rps_pkg::OP_APPEND, 64'h0123456789abcdef, 15, 0));
        pending_reqs.push_back(make_req(rps_pkg::OP_APPEND, 64'h55, 0, 0));
        pending_reqs.push_back(make_req(rps_pkg::OP_APPEND, 64'haa55aa55_00112233, 5, 0));
        pending_reqs.push_back(make_req(rps_pkg::OP_SEARCH, 64'h89abcdef, 0, 0));
        pending_reqs.push_back(make_req(rps_pkg::OP_SEARCH, '1, 0, 0));
        pending_reqs.push_back(make_req(rps_pkg::OP_SEARCH, 64'h12345678, 0, 0));
        pending_reqs.push_back(make_req(rps_pkg::OP_READ, 64'h0, 15, 3));
        pending_reqs.push_back(make_req(rps_pkg::OP_READ, 64'h0, 8, 14));
        pending_reqs.push_back(make_req(rps_pkg::OP_READ, 64'h0, 0, 21));
        pending_reqs.push_back(make_req(rps_pkg::OP_READ, 64'h0, 0, 22));
        pending_reqs.push_back(make_req(rps_pkg::OP_READ, 64'h0, 8, 12'hfff));
        pending_reqs.push_back(make_req(rps_pkg::OP_CLEAR, '1, 15, 12'hfff));
        pending_reqs.push_back(make_req(rps_pkg::OP_READ, 64'h0, 1, 0));
        pending_reqs.push_back(make_req(rps_pkg::OP_SEARCH, 64'h0, 0, 0));
        // short record after a clear, read past the fill, miss, clear again
        pending_reqs.push_back(make_req(rps_pkg::OP_APPEND, 64'h1, 1, 0));
        pending_reqs.push_back(make_req(rps_pkg::OP_READ, 64'h0, 8, 4088));
        pending_reqs.push_back(make_req(rps_pkg::OP_SEARCH, 64'hffff_ffff_dead_beef, 0, 0));
        pending_reqs.push_back(make_req(rps_pkg::OP_CLEAR, 64'h0, 0, 0));
        drain();

        // receiver stalls long while sender keeps offering
        write_reg(rps_pkg::CFG_KEY_BYTES, 0);
        write_reg(rps_pkg::CFG_ENTRY_BYTES, 0);
        hold_cycles = 400;
        send_idle_pct = 12;
        recv_idle_pct = 87;
        queue_random(60);
        drain();

        write_reg(rps_pkg::CFG_KEY_BYTES, 8);
        write_reg(rps_pkg::CFG_ENTRY_BYTES, 64);
        queue_random(50);
        drain();

        write_reg(rps_pkg::CFG_KEY_BYTES, 15);
        write_reg(rps_pkg::CFG_ENTRY_BYTES, 127);
        send_idle_pct = 87;
        recv_idle_pct = 12;
        queue_random(40);
        drain();

        write_reg(rps_pkg::CFG_KEY_BYTES, $urandom_range(8, 1));
        write_reg(rps_pkg::CFG_ENTRY_BYTES, $urandom_range(24, 1));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(58);
        drain();

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### filelist.f
sv/rps_pkg.sv
sv/rps_page_mem.sv
sv/record_page_store_with_key_search_top.sv
tb/sv/tb.sv
